// ===== hdl/puc_pkg.sv =====
// puc_pkg: shared constants, register codes, pipeline bus types and the arctan table
// for the polar unwrap coordinate map; no dependencies
package puc_pkg;

    localparam int COORD_BITS   = 12;
    localparam int ANGLE_BITS   = 16;
    localparam int FRAC_BITS    = 8;
    localparam int OUT_BITS     = 22;
    localparam int DIM_BITS     = COORD_BITS + 1;
    localparam int NUM_BITS     = COORD_BITS + ANGLE_BITS;
    localparam int PHASE_BITS   = 32;
    localparam int CORDIC_STEPS = 24;
    localparam int STEP_BITS    = 5;
    localparam int TRIG_BITS    = 33;
    localparam int EDGE_BITS    = COORD_BITS + 3;
    localparam int RAD_BITS     = COORD_BITS + 4;
    localparam int ACC_BITS     = RAD_BITS + TRIG_BITS;
    localparam int Q_BITS       = 30;
    localparam int ADDR_BITS    = 5;
    localparam int LATENCY      = NUM_BITS + CORDIC_STEPS + 3;

    localparam logic signed [TRIG_BITS-1:0] CORDIC_GAIN = TRIG_BITS'(64'sd652032874);
    localparam logic signed [TRIG_BITS-1:0] HALF_QUAD   = TRIG_BITS'(64'sd536870912);
    localparam logic [PHASE_BITS-1:0]       QUAD_OFFSET = 32'h2000_0000;

    typedef enum logic [2:0] {
        REG_CENTER_X     = 3'd0,
        REG_CENTER_Y     = 3'd1,
        REG_INNER_RADIUS = 3'd2,
        REG_OUTER_RADIUS = 3'd3,
        REG_MAP_WIDTH    = 3'd4,
        REG_MAP_HEIGHT   = 3'd5,
        REG_IMAGE_WIDTH  = 3'd6,
        REG_IMAGE_HEIGHT = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic                  valid;
        logic [DIM_BITS-1:0]   rem;
        logic [NUM_BITS-1:0]   numq;
        logic [COORD_BITS-1:0] row;
    } div_bus_t;

    typedef struct packed {
        logic                        valid;
        logic [1:0]                  quad;
        logic [COORD_BITS-1:0]       row;
        logic signed [TRIG_BITS-1:0] x;
        logic signed [TRIG_BITS-1:0] y;
        logic signed [TRIG_BITS-1:0] z;
    } cordic_bus_t;

    // arctan of 2^-i in 2^-32 turns
    function automatic logic signed [TRIG_BITS-1:0] atan_turns(input logic [STEP_BITS-1:0] idx);
        logic [31:0] a;
        case (idx)
            5'd0:    a = 32'd536870912;
            5'd1:    a = 32'd316933406;
            5'd2:    a = 32'd167458907;
            5'd3:    a = 32'd85004756;
            5'd4:    a = 32'd42667331;
            5'd5:    a = 32'd21354465;
            5'd6:    a = 32'd10680862;
            5'd7:    a = 32'd5340245;
            5'd8:    a = 32'd2670163;
            5'd9:    a = 32'd1335087;
            5'd10:   a = 32'd667544;
            5'd11:   a = 32'd333772;
            5'd12:   a = 32'd166886;
            5'd13:   a = 32'd83443;
            5'd14:   a = 32'd41722;
            5'd15:   a = 32'd20861;
            5'd16:   a = 32'd10430;
            5'd17:   a = 32'd5215;
            5'd18:   a = 32'd2608;
            5'd19:   a = 32'd1304;
            5'd20:   a = 32'd652;
            5'd21:   a = 32'd326;
            5'd22:   a = 32'd163;
            5'd23:   a = 32'd81;
            default: a = 32'd0;
        endcase
        return $signed({{(TRIG_BITS-32){1'b0}}, a});
    endfunction

endpackage

// ===== hdl/polar_unwrap_coordinate_map.sv =====
// polar_unwrap_coordinate_map: top level, register file, divider and CORDIC chains
// depends on puc_pkg, puc_div_cell, puc_cordic_cell, puc_out_stage

// Takes one map pixel per clock and never stalls: busy stays low, so an item may be
// given in every cycle. Each result leaves on done/src_x/src_y once its item has
// passed 28 divider cells (column-to-phase division), 24 CORDIC cells and the
// rotation, multiply and rounding stages, shown for one cycle only; the receiver
// has to take it then. The user writes registers over the APB port while no item
// is in flight, unchecked by the block; radius clamping follows a write next cycle.
module polar_unwrap_coordinate_map (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [puc_pkg::COORD_BITS-1:0]       map_col,
    input  logic [puc_pkg::COORD_BITS-1:0]       map_row,
    output logic                                 done,
    output logic signed [puc_pkg::OUT_BITS-1:0]  src_x,
    output logic signed [puc_pkg::OUT_BITS-1:0]  src_y,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [puc_pkg::ADDR_BITS-1:0]        paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);

    localparam int CB = puc_pkg::COORD_BITS;
    localparam int DB = puc_pkg::DIM_BITS;
    localparam int EB = puc_pkg::EDGE_BITS;
    localparam int AB = puc_pkg::ANGLE_BITS;

    logic [CB-1:0] center_x_reg;
    logic [CB-1:0] center_y_reg;
    logic [CB-1:0] inner_radius_reg;
    logic [CB-1:0] outer_radius_reg;
    logic [DB-1:0] map_width_reg;
    logic [DB-1:0] map_rows_reg;
    logic [DB-1:0] image_width_reg;
    logic [DB-1:0] image_height_reg;
    logic          wr_en;
    puc_pkg::reg_idx_t idx;

    logic signed [EB-1:0] cx_s, cy_s, ri_s, ro_s, lo_r, hi_r, edge_a, edge_b, edge_d, hi_c;
    logic signed [EB-1:0] r_in_next;
    logic signed [EB-1:0] r_in_reg;
    logic [DB-1:0]        w_eff;

    puc_pkg::div_bus_t    div_bus [0:puc_pkg::NUM_BITS];
    puc_pkg::cordic_bus_t cor_bus [0:puc_pkg::CORDIC_STEPS];

    logic [AB-1:0]                   phase;
    logic [puc_pkg::PHASE_BITS-1:0]  shifted;

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = puc_pkg::reg_idx_t'(paddr[puc_pkg::ADDR_BITS-1:2]);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg     <= '0;
            center_y_reg     <= '0;
            inner_radius_reg <= '0;
            outer_radius_reg <= '0;
            map_width_reg    <= DB'(1);
            map_rows_reg     <= DB'(1);
            image_width_reg  <= DB'(1);
            image_height_reg <= DB'(1);
        end
        else if (wr_en)
        begin
            case (idx)
                puc_pkg::REG_CENTER_X:     center_x_reg     <= pwdata[CB-1:0];
                puc_pkg::REG_CENTER_Y:     center_y_reg     <= pwdata[CB-1:0];
                puc_pkg::REG_INNER_RADIUS: inner_radius_reg <= pwdata[CB-1:0];
                puc_pkg::REG_OUTER_RADIUS: outer_radius_reg <= pwdata[CB-1:0];
                puc_pkg::REG_MAP_WIDTH:    map_width_reg    <= pwdata[DB-1:0];
                puc_pkg::REG_MAP_HEIGHT:   map_rows_reg     <= pwdata[DB-1:0];
                puc_pkg::REG_IMAGE_WIDTH:  image_width_reg  <= pwdata[DB-1:0];
                puc_pkg::REG_IMAGE_HEIGHT: image_height_reg <= pwdata[DB-1:0];
                default: ;
            endcase
        end
    end

    // register read-back
    always_comb
    begin
        case (idx)
            puc_pkg::REG_CENTER_X:     prdata = 32'(center_x_reg);
            puc_pkg::REG_CENTER_Y:     prdata = 32'(center_y_reg);
            puc_pkg::REG_INNER_RADIUS: prdata = 32'(inner_radius_reg);
            puc_pkg::REG_OUTER_RADIUS: prdata = 32'(outer_radius_reg);
            puc_pkg::REG_MAP_WIDTH:    prdata = 32'(map_width_reg);
            puc_pkg::REG_MAP_HEIGHT:   prdata = 32'(map_rows_reg);
            puc_pkg::REG_IMAGE_WIDTH:  prdata = 32'(image_width_reg);
            puc_pkg::REG_IMAGE_HEIGHT: prdata = 32'(image_height_reg);
            default:                   prdata = '0;
        endcase
    end

    // radius ordering and clamping to the nearest image edge
    always_comb
    begin
        cx_s   = $signed(EB'(center_x_reg));
        cy_s   = $signed(EB'(center_y_reg));
        ri_s   = $signed(EB'(inner_radius_reg));
        ro_s   = $signed(EB'(outer_radius_reg));
        lo_r   = (ri_s < ro_s) ? ri_s : ro_s;
        hi_r   = (ri_s < ro_s) ? ro_s : ri_s;
        edge_a = (cx_s < cy_s) ? cx_s : cy_s;
        edge_b = $signed(EB'(image_width_reg)) - cx_s;
        edge_d = $signed(EB'(image_height_reg)) - cy_s;
        edge_b = (edge_b < edge_d) ? edge_b : edge_d;
        edge_a = (edge_a < edge_b) ? edge_a : edge_b;
        hi_c   = (hi_r < edge_a) ? hi_r : edge_a;
        r_in_next = (lo_r < hi_c) ? lo_r : hi_c;
    end

    always_ff @(posedge clk)
    begin
        r_in_reg <= r_in_next;
    end

    // divider chain input: rounded column times one turn over width
    assign w_eff = (map_width_reg == '0) ? DB'(1) : map_width_reg;
    assign div_bus[0] = '{valid: start && !busy,
                          rem:   '0,
                          numq:  {map_col, {AB{1'b0}}}
                                 + puc_pkg::NUM_BITS'(w_eff[DB-1:1]),
                          row:   map_row};

    for (genvar i = 0; i < puc_pkg::NUM_BITS; i++)
    begin : g_div
        puc_div_cell u_div (
            .clk     (clk),
            .rst_n   (rst_n),
            .divisor (w_eff),
            .bus_in  (div_bus[i]),
            .bus_out (div_bus[i+1])
        );
    end

    // negate phase, fold into quadrant and residual angle
    always_comb
    begin
        phase   = AB'(0) - div_bus[puc_pkg::NUM_BITS].numq[AB-1:0];
        shifted = {phase, {(puc_pkg::PHASE_BITS-AB){1'b0}}} + puc_pkg::QUAD_OFFSET;
    end

    assign cor_bus[0] = '{valid: div_bus[puc_pkg::NUM_BITS].valid,
                          quad:  shifted[31:30],
                          row:   div_bus[puc_pkg::NUM_BITS].row,
                          x:     puc_pkg::CORDIC_GAIN,
                          y:     '0,
                          z:     $signed({{(puc_pkg::TRIG_BITS-30){1'b0}}, shifted[29:0]})
                                 - puc_pkg::HALF_QUAD};

    for (genvar k = 0; k < puc_pkg::CORDIC_STEPS; k++)
    begin : g_cordic
        puc_cordic_cell u_cordic (
            .clk     (clk),
            .rst_n   (rst_n),
            .step    (puc_pkg::STEP_BITS'(k)),
            .bus_in  (cor_bus[k]),
            .bus_out (cor_bus[k+1])
        );
    end

    puc_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .bus_in     (cor_bus[puc_pkg::CORDIC_STEPS]),
        .r_in       (r_in_reg),
        .map_rows   (map_rows_reg),
        .center_x   (center_x_reg),
        .center_y   (center_y_reg),
        .done       (done),
        .src_x      (src_x),
        .src_y      (src_y)
    );

endmodule

// ===== hdl/puc_div_cell.sv =====
// puc_div_cell: one restoring division step, one quotient bit per cell
// depends on puc_pkg
module puc_div_cell (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [puc_pkg::DIM_BITS-1:0]        divisor,
    input  puc_pkg::div_bus_t                   bus_in,
    output puc_pkg::div_bus_t                   bus_out
);

    logic [puc_pkg::DIM_BITS:0]    trial;
    logic [puc_pkg::DIM_BITS:0]    diff;
    logic                          ge;
    logic                          valid_reg;
    logic [puc_pkg::DIM_BITS-1:0]  rem_reg;
    logic [puc_pkg::DIM_BITS-1:0]  rem_next;
    logic [puc_pkg::NUM_BITS-1:0]  numq_reg;
    logic [puc_pkg::NUM_BITS-1:0]  numq_next;
    logic [puc_pkg::COORD_BITS-1:0] row_reg;

    // shift in the next numerator bit, subtract when it fits
    always_comb
    begin
        trial     = {bus_in.rem, bus_in.numq[puc_pkg::NUM_BITS-1]};
        diff      = trial - {1'b0, divisor};
        ge        = (trial >= {1'b0, divisor});
        rem_next  = ge ? diff[puc_pkg::DIM_BITS-1:0] : trial[puc_pkg::DIM_BITS-1:0];
        numq_next = {bus_in.numq[puc_pkg::NUM_BITS-2:0], ge};
    end

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= bus_in.valid;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        numq_reg <= numq_next;
        row_reg  <= bus_in.row;
    end

    assign bus_out = '{valid: valid_reg, rem: rem_reg, numq: numq_reg, row: row_reg};

endmodule

// ===== hdl/puc_cordic_cell.sv =====
// puc_cordic_cell: one CORDIC rotation step in Q30, phase in 2^-32 turns
// depends on puc_pkg
module puc_cordic_cell (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [puc_pkg::STEP_BITS-1:0]       step,
    input  puc_pkg::cordic_bus_t                bus_in,
    output puc_pkg::cordic_bus_t                bus_out
);

    logic signed [puc_pkg::TRIG_BITS-1:0] dx;
    logic signed [puc_pkg::TRIG_BITS-1:0] dy;
    logic signed [puc_pkg::TRIG_BITS-1:0] atan;
    logic signed [puc_pkg::TRIG_BITS-1:0] x_next;
    logic signed [puc_pkg::TRIG_BITS-1:0] y_next;
    logic signed [puc_pkg::TRIG_BITS-1:0] z_next;
    logic signed [puc_pkg::TRIG_BITS-1:0] x_reg;
    logic signed [puc_pkg::TRIG_BITS-1:0] y_reg;
    logic signed [puc_pkg::TRIG_BITS-1:0] z_reg;
    logic [1:0]                           quad_reg;
    logic [puc_pkg::COORD_BITS-1:0]       row_reg;
    logic                                 valid_reg;

    // rotate towards zero residual angle
    always_comb
    begin
        dx   = bus_in.y >>> step;
        dy   = bus_in.x >>> step;
        atan = puc_pkg::atan_turns(step);
        if (!bus_in.z[puc_pkg::TRIG_BITS-1])
        begin
            x_next = bus_in.x - dx;
            y_next = bus_in.y + dy;
            z_next = bus_in.z - atan;
        end
        else
        begin
            x_next = bus_in.x + dx;
            y_next = bus_in.y - dy;
            z_next = bus_in.z + atan;
        end
    end

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= bus_in.valid;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        quad_reg <= bus_in.quad;
        row_reg  <= bus_in.row;
    end

    assign bus_out = '{valid: valid_reg, quad: quad_reg, row: row_reg,
                       x: x_reg, y: y_reg, z: z_reg};

endmodule

// ===== hdl/puc_out_stage.sv =====
// puc_out_stage: quadrant rotation, radius, multiply, centre add, rounding, saturation
// depends on puc_pkg
module puc_out_stage (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  puc_pkg::cordic_bus_t                   bus_in,
    input  logic signed [puc_pkg::EDGE_BITS-1:0]   r_in,
    input  logic [puc_pkg::DIM_BITS-1:0]           map_rows,
    input  logic [puc_pkg::COORD_BITS-1:0]         center_x,
    input  logic [puc_pkg::COORD_BITS-1:0]         center_y,
    output logic                                   done,
    output logic signed [puc_pkg::OUT_BITS-1:0]    src_x,
    output logic signed [puc_pkg::OUT_BITS-1:0]    src_y
);

    localparam int SH = puc_pkg::Q_BITS - puc_pkg::FRAC_BITS;
    localparam logic signed [puc_pkg::ACC_BITS-1:0] ROUND_HALF =
        puc_pkg::ACC_BITS'(64'sd1 <<< (SH - 1));
    localparam logic signed [puc_pkg::ACC_BITS-1:0] OUT_MAX =
        puc_pkg::ACC_BITS'((64'sd1 <<< (puc_pkg::OUT_BITS - 1)) - 64'sd1);
    localparam logic signed [puc_pkg::ACC_BITS-1:0] OUT_MIN =
        puc_pkg::ACC_BITS'(-(64'sd1 <<< (puc_pkg::OUT_BITS - 1)));

    logic signed [puc_pkg::TRIG_BITS-1:0] sn_next;
    logic signed [puc_pkg::TRIG_BITS-1:0] cs_next;
    logic signed [puc_pkg::RAD_BITS-1:0]  radius_next;
    logic signed [puc_pkg::TRIG_BITS-1:0] sn_reg;
    logic signed [puc_pkg::TRIG_BITS-1:0] cs_reg;
    logic signed [puc_pkg::RAD_BITS-1:0]  radius_reg;
    logic                                 v1_reg;
    logic signed [puc_pkg::ACC_BITS-1:0]  prod_x_reg;
    logic signed [puc_pkg::ACC_BITS-1:0]  prod_y_reg;
    logic                                 v2_reg;
    logic signed [puc_pkg::ACC_BITS-1:0]  acc_x;
    logic signed [puc_pkg::ACC_BITS-1:0]  acc_y;
    logic signed [puc_pkg::ACC_BITS-1:0]  sh_x;
    logic signed [puc_pkg::ACC_BITS-1:0]  sh_y;
    logic signed [puc_pkg::OUT_BITS-1:0]  src_x_next;
    logic signed [puc_pkg::OUT_BITS-1:0]  src_y_next;
    logic signed [puc_pkg::OUT_BITS-1:0]  src_x_reg;
    logic signed [puc_pkg::OUT_BITS-1:0]  src_y_reg;
    logic                                 done_reg;

    function automatic logic signed [puc_pkg::OUT_BITS-1:0] saturate(
        input logic signed [puc_pkg::ACC_BITS-1:0] v);
        logic signed [puc_pkg::OUT_BITS-1:0] r;
        if (v > OUT_MAX)
            r = OUT_MAX[puc_pkg::OUT_BITS-1:0];
        else if (v < OUT_MIN)
            r = OUT_MIN[puc_pkg::OUT_BITS-1:0];
        else
            r = v[puc_pkg::OUT_BITS-1:0];
        return r;
    endfunction

    // quadrant rotation and radius
    always_comb
    begin
        case (bus_in.quad)
            2'd0:
            begin
                cs_next = bus_in.x;
                sn_next = bus_in.y;
            end
            2'd1:
            begin
                cs_next = -bus_in.y;
                sn_next = bus_in.x;
            end
            2'd2:
            begin
                cs_next = -bus_in.x;
                sn_next = -bus_in.y;
            end
            default:
            begin
                cs_next = bus_in.y;
                sn_next = -bus_in.x;
            end
        endcase
        radius_next = puc_pkg::RAD_BITS'(r_in)
                    + $signed({{(puc_pkg::RAD_BITS-puc_pkg::DIM_BITS){1'b0}}, map_rows})
                    - $signed({{(puc_pkg::RAD_BITS-puc_pkg::COORD_BITS){1'b0}}, bus_in.row});
    end

    // centre add and rounding to the output step
    always_comb
    begin
        acc_x = prod_x_reg + ROUND_HALF
              + $signed(puc_pkg::ACC_BITS'({center_x, {puc_pkg::Q_BITS{1'b0}}}));
        acc_y = prod_y_reg + ROUND_HALF
              + $signed(puc_pkg::ACC_BITS'({center_y, {puc_pkg::Q_BITS{1'b0}}}));
        sh_x  = acc_x >>> SH;
        sh_y  = acc_y >>> SH;
        src_x_next = saturate(sh_x);
        src_y_next = saturate(sh_y);
    end

    // stage valid flags and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= bus_in.valid;
            v2_reg   <= v1_reg;
            done_reg <= v2_reg;
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        sn_reg     <= sn_next;
        cs_reg     <= cs_next;
        radius_reg <= radius_next;
        prod_x_reg <= radius_reg * sn_reg;
        prod_y_reg <= radius_reg * cs_reg;
        src_x_reg  <= src_x_next;
        src_y_reg  <= src_y_next;
    end

    assign done  = done_reg;
    assign src_x = src_x_reg;
    assign src_y = src_y_reg;

endmodule

// ===== hdl/puc_checker.sv =====
// puc_checker: port-level assertions for polar_unwrap_coordinate_map, bound to the top
// depends on puc_pkg
module puc_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input logic psel,
    input logic penable,
    input logic pready
);

    // every accepted item yields its result after the fixed latency
    a_item_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(puc_pkg::LATENCY) done)
        else $error("accepted item gave no result");

    // no result without an item taken the latency before
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, puc_pkg::LATENCY))
        else $error("result without item");

    // the block never holds off items
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised");

    // configuration access completes without wait states
    a_apb_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable) |-> pready)
        else $error("apb access stalled");

endmodule

bind polar_unwrap_coordinate_map puc_checker u_puc_checker (.*);
